// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ccr_pkg.sv =====
// shared constants, codes and types of the chunked config reassembler
package ccr_pkg;

    localparam int CHUNK_BYTES = 200;
    localparam int MAX_CHUNKS  = 8;
    localparam int STORE_DEPTH = CHUNK_BYTES * MAX_CHUNKS;
    localparam int START_LEN   = CHUNK_BYTES + 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int FQ_DEPTH    = 2;
    localparam int FQ_CNT_W    = 2;
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_W    = 2;
    localparam int OQ_CNT_W    = 3;

    typedef enum logic [1:0] {
        MODE_ABANDON = 2'd0,
        MODE_START   = 2'd1,
        MODE_CONT    = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_REJECTED = 3'd0,
        ST_SINGLE   = 3'd1,
        ST_ACCEPTED = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_READ     = 3'd4
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [10:0] read_index;
        logic        read_ok;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } link_t;

    typedef struct packed {
        status_t     status;
        logic [10:0] received;
        logic [15:0] total;
        logic        active;
        logic [7:0]  rdata;
    } result_t;

    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
        logic                full;
    } oq_stat_t;

endpackage

// ===== hw/rtl/ccr_front.sv =====
// front end: accepts input transactions, classifies them, queues them for the back end
module ccr_front import ccr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [10:0] read_index,
    output link_t       link,
    input  logic        take
);

    item_t               q_reg [FQ_DEPTH];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                accept;
    logic                take_ok;
    item_t               cls;

    assign full    = (cnt_reg == FQ_CNT_W'(FQ_DEPTH));
    assign accept  = push && !full;
    assign take_ok = take && (cnt_reg != '0);

    // classify: decode mode and range-check the read position
    always_comb
    begin
        cls.mode       = mode_t'(mode);
        cls.data_byte  = data_byte;
        cls.frame_end  = frame_end;
        cls.read_index = read_index;
        cls.read_ok    = ({1'b0, read_index} < 12'(STORE_DEPTH));
    end

    always_comb
    begin
        wr_ptr_next = accept  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take_ok ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + FQ_CNT_W'(accept) - FQ_CNT_W'(take_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    assign link.valid = (cnt_reg != '0);
    assign link.item  = q_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/ccr_back.sv =====
// back end: transfer state, record store and result generation
module ccr_back import ccr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  link_t    link,
    output logic     take,
    input  oq_stat_t ostat,
    output logic     res_push,
    output result_t  res
);

    logic [7:0]        mem [STORE_DEPTH];

    logic              active_reg, active_next;
    logic [15:0]       total_reg, total_next;
    logic [10:0]       rcv_reg, rcv_next;
    logic [3:0]        chunk_reg, chunk_next;
    logic [7:0]        fbc_reg, fbc_next;

    logic              s2_valid_reg;
    result_t           s2_res_reg;
    logic              s2_rok_reg;
    logic [7:0]        rdata_reg;

    logic              issue;
    item_t             it;
    logic              gen;
    status_t           st;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic              rok;

    logic [7:0]        c;
    logic [7:0]        n;
    logic [11:0]       cont_pos;
    logic [16:0]       owed;
    logic [16:0]       n17;
    logic              owed_neg;
    logic              bad_cont;
    logic [10:0]       rcv_sum;

    assign it    = link.item;
    assign issue = link.valid && (({1'b0, ostat.count} + 4'(s2_valid_reg)) < 4'(OQ_DEPTH));
    assign take  = issue;

    always_comb
    begin
        c        = fbc_reg;
        n        = (c == 8'hFF) ? 8'hFF : c + 8'd1;
        cont_pos = {1'b0, rcv_reg} + {4'b0, c};
        owed     = {1'b0, total_reg} - {6'b0, rcv_reg};
        owed_neg = owed[16];
        n17      = {9'b0, n};
        bad_cont = (n > 8'(CHUNK_BYTES))
                || (!owed_neg && (n17 > owed))
                || ((n < 8'(CHUNK_BYTES)) && (owed_neg || (n17 != owed)))
                || (chunk_reg >= 4'(MAX_CHUNKS));
        rcv_sum  = rcv_reg + {3'b0, n};

        active_next = active_reg;
        total_next  = total_reg;
        rcv_next    = rcv_reg;
        chunk_next  = chunk_reg;
        fbc_next    = fbc_reg;
        gen         = 1'b0;
        st          = ST_REJECTED;
        we          = 1'b0;
        waddr       = '0;
        re          = 1'b0;
        rok         = 1'b0;

        unique case (it.mode)
            MODE_ABANDON:
            begin
                active_next = 1'b0;
                total_next  = '0;
                rcv_next    = '0;
                chunk_next  = '0;
                fbc_next    = '0;
            end
            MODE_READ:
            begin
                gen = 1'b1;
                st  = ST_READ;
                re  = 1'b1;
                rok = it.read_ok;
            end
            MODE_START:
            begin
                // length header bytes first, then one chunk of data
                if (c == 8'd0)
                begin
                    total_next = {8'h00, it.data_byte};
                end
                else if (c == 8'd1)
                begin
                    total_next = {it.data_byte, total_reg[7:0]};
                end
                else if (c <= 8'(CHUNK_BYTES + 1))
                begin
                    we    = 1'b1;
                    waddr = ADDR_W'(c - 8'd2);
                end
                if (!it.frame_end)
                begin
                    fbc_next = n;
                end
                else
                begin
                    fbc_next = '0;
                    gen      = 1'b1;
                    if (n < 8'(START_LEN))
                    begin
                        st = ST_SINGLE;
                    end
                    else if ((n == 8'(START_LEN)) && (total_next > 16'(CHUNK_BYTES))
                             && (total_next <= 16'(STORE_DEPTH)))
                    begin
                        st = ST_ACCEPTED;
                    end
                    else
                    begin
                        st = ST_REJECTED;
                    end
                    if (st == ST_ACCEPTED)
                    begin
                        active_next = 1'b1;
                        rcv_next    = 11'(CHUNK_BYTES);
                        chunk_next  = 4'd1;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        total_next  = '0;
                        rcv_next    = '0;
                        chunk_next  = '0;
                    end
                end
            end
            MODE_CONT:
            begin
                if (active_reg && (cont_pos < 12'(STORE_DEPTH)))
                begin
                    we    = 1'b1;
                    waddr = ADDR_W'(cont_pos);
                end
                if (!it.frame_end)
                begin
                    fbc_next = n;
                end
                else
                begin
                    fbc_next = '0;
                    gen      = 1'b1;
                    if (!active_reg)
                    begin
                        st = ST_REJECTED;
                    end
                    else if (bad_cont)
                    begin
                        st          = ST_REJECTED;
                        active_next = 1'b0;
                        total_next  = '0;
                        rcv_next    = '0;
                        chunk_next  = '0;
                    end
                    else
                    begin
                        rcv_next   = rcv_sum;
                        chunk_next = chunk_reg + 4'd1;
                        if ({5'b0, rcv_sum} == total_reg)
                        begin
                            active_next = 1'b0;
                            st          = ST_COMPLETE;
                        end
                        else
                        begin
                            st = ST_ACCEPTED;
                        end
                    end
                end
            end
            default:
            begin
                gen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            total_reg    <= '0;
            rcv_reg      <= '0;
            chunk_reg    <= '0;
            fbc_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= issue && gen;
            if (issue)
            begin
                active_reg <= active_next;
                total_reg  <= total_next;
                rcv_reg    <= rcv_next;
                chunk_reg  <= chunk_next;
                fbc_reg    <= fbc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_res_reg.status   <= st;
            s2_res_reg.received <= rcv_next;
            s2_res_reg.total    <= total_next;
            s2_res_reg.active   <= active_next;
            s2_res_reg.rdata    <= '0;
            s2_rok_reg          <= rok;
        end
    end

    // record store: one write or one read per transaction
    always_ff @(posedge clk)
    begin
        if (issue && we)
        begin
            mem[waddr] <= it.data_byte;
        end
        if (issue && re)
        begin
            rdata_reg <= mem[ADDR_W'(it.read_index)];
        end
    end

    always_comb
    begin
        res       = s2_res_reg;
        res.rdata = s2_rok_reg ? rdata_reg : 8'h00;
    end

    assign res_push = s2_valid_reg;

endmodule

// ===== hw/rtl/ccr_outq.sv =====
// result queue toward the consumer
module ccr_outq import ccr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     res_push,
    input  result_t  res_in,
    output oq_stat_t ostat,
    output logic     empty,
    input  logic     pop,
    output result_t  head
);

    result_t             q_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                pop_ok;

    assign empty  = (cnt_reg == '0);
    assign pop_ok = pop && !empty;

    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + OQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok   ? rd_ptr_reg + OQ_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + OQ_CNT_W'(res_push) - OQ_CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

    assign head        = q_reg[rd_ptr_reg];
    assign ostat.count = cnt_reg;
    assign ostat.full  = (cnt_reg == OQ_CNT_W'(OQ_DEPTH));

endmodule

// ===== hw/rtl/chunked_config_reassembler.sv =====
// top level of the chunked config reassembler: front end, back end and result queue
// path: front queue, back-end result register, then result queue; issue can stall
// throughput: one input transaction per cycle while full is low, set by the
//   single-port record store and the back-end state update
// reset: asynchronous, clears the transfer counters, flags and queue pointers;
//   the record store is not cleared and reads as undefined until written
`include "assert_macros.svh"

module chunked_config_reassembler import ccr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input side, queue style
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [10:0] read_index,
    // result side, queue style
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [10:0] received_bytes,
    output logic [15:0] declared_total,
    output logic        transfer_active,
    output logic [7:0]  read_data
);

    // front to back: classified transaction and its take strobe
    link_t    link;
    logic     take;

    // back to result queue
    logic     res_push;
    result_t  res;
    oq_stat_t ostat;
    result_t  head;

    // front end registers each transaction into a two-entry queue so that
    // the link side never waits on the back end directly
    ccr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .read_index (read_index),
        .link       (link),
        .take       (take)
    );

    // back end owns the transfer state and the record store; it issues a
    // transaction only when the result queue has room for it and the one in flight
    ccr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .link     (link),
        .take     (take),
        .ostat    (ostat),
        .res_push (res_push),
        .res      (res)
    );

    // result queue decouples the consumer from the back end
    ccr_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .ostat    (ostat),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign status          = head.status;
    assign received_bytes  = head.received;
    assign declared_total  = head.total;
    assign transfer_active = head.active;
    assign read_data       = head.rdata;

    // the issue credit must keep the result queue from overflowing
    `CCR_ASSERT_IMP(a_outq_no_overflow, clk, rst_n, res_push, !ostat.full)

    // a completed transfer is no longer active
    `CCR_ASSERT_IMP(a_complete_inactive, clk, rst_n,
        (!empty && (status == ST_COMPLETE)), !transfer_active)

    // a single-frame record leaves no transfer state behind
    `CCR_ASSERT_IMP(a_single_clear, clk, rst_n, (!empty && (status == ST_SINGLE)),
        ((declared_total == 16'd0) && (received_bytes == 11'd0) && !transfer_active))

    // only read results carry record data
    `CCR_ASSERT_IMP(a_rdata_only_read, clk, rst_n, (!empty && (status != ST_READ)),
        (read_data == 8'h00))

endmodule

// ===== sim/chunked_config_reassembler_test.sv =====
// self-checking testbench of the chunked config reassembler with a built-in transfer predictor
`timescale 1ns / 1ps

module chunked_config_reassembler_test import ccr_pkg::*;;

    // run shape
    localparam int IDLE_PERCENT = 37;
    localparam int HOLD_CYCLES  = 400;   // receiver hold-off in the back-pressure test
    localparam int STALL_LIMIT  = 3000;  // cycles without any transaction before giving up
    localparam int RANDOM_ITEMS = 90;
    localparam int DRAIN_CYCLES = 8;     // extra wait once every report is checked

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  mode = MODE_ABANDON;
    logic [7:0]  data_byte = '0;
    logic        frame_end = 1'b0;
    logic [10:0] read_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  status;
    logic [10:0] received_bytes;
    logic [15:0] declared_total;
    logic        transfer_active;
    logic [7:0]  read_data;

    chunked_config_reassembler DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .data_byte       (data_byte),
        .frame_end       (frame_end),
        .read_index      (read_index),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .received_bytes  (received_bytes),
        .declared_total  (declared_total),
        .transfer_active (transfer_active),
        .read_data       (read_data)
    );

    always #1 clk = ~clk;

    // shadow copy of the reassembler state, updated once per accepted input transaction
    logic [7:0]  shadow_record [STORE_DEPTH];
    bit          shadow_written [STORE_DEPTH];   // only written bytes may be read back
    bit          shadow_active = 1'b0;
    int unsigned shadow_total = 0;
    int unsigned shadow_received = 0;
    int unsigned shadow_chunks = 0;
    int unsigned shadow_frame_len = 0;

    // reports predicted but not yet popped, oldest first
    result_t     pending_reports [$];

    // traffic control shared by the sender, the receiver and the tests
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;

    // bookkeeping for the summary and the verdict
    int unsigned items_sent = 0;
    int unsigned reports_checked = 0;
    int unsigned mismatches = 0;
    int unsigned status_tally [5];
    int unsigned quiet_cycles = 0;
    int unsigned input_stall_cycles = 0;

    function automatic void drop_shadow_transfer();
        shadow_active   = 1'b0;
        shadow_total    = 0;
        shadow_received = 0;
        shadow_chunks   = 0;
    endfunction

    function automatic void store_shadow(int unsigned pos, logic [7:0] value);
        if (pos < STORE_DEPTH)
        begin
            shadow_record[pos]  = value;
            shadow_written[pos] = 1'b1;
        end
    endfunction

    // advances the shadow state by one input byte; returns 1 when the byte closes
    // a frame or is a read, with the report the block should give for it
    function automatic bit predict_report(mode_t m, logic [7:0] d, logic fe,
                                          logic [10:0] idx, output result_t rep);
        int unsigned c;
        int unsigned n;
        int unsigned owed;
        int unsigned held_total;
        status_t     st;
        rep = '0;
        if (m == MODE_ABANDON)
        begin
            drop_shadow_transfer();
            shadow_frame_len = 0;
            return 1'b0;
        end
        if (m == MODE_READ)
        begin
            st = ST_READ;
            if (idx < STORE_DEPTH)
                rep.rdata = shadow_record[idx];
        end
        else
        begin
            c = shadow_frame_len;
            // every byte lands by its own mode, even inside a frame of the other kind
            if (m == MODE_START)
            begin
                if (c == 0)
                    shadow_total = d;
                else if (c == 1)
                    shadow_total = (shadow_total & 32'hFF) | (32'(d) << 8);
                else if (c - 2 < CHUNK_BYTES)
                    store_shadow(c - 2, d);
            end
            else if (shadow_active)
            begin
                store_shadow(shadow_received + c, d);
            end
            n = (c < 255) ? c + 1 : 255;   // frame length saturates
            if (!fe)
            begin
                shadow_frame_len = n;
                return 1'b0;
            end
            shadow_frame_len = 0;
            if (m == MODE_START)
            begin
                // a start frame always abandons what was in progress
                held_total = shadow_total;
                drop_shadow_transfer();
                if (n < START_LEN)
                    st = ST_SINGLE;
                else if (n > START_LEN || held_total <= CHUNK_BYTES || held_total > STORE_DEPTH)
                    st = ST_REJECTED;
                else
                begin
                    st              = ST_ACCEPTED;
                    shadow_active   = 1'b1;
                    shadow_total    = held_total;
                    shadow_received = CHUNK_BYTES;
                    shadow_chunks   = 1;
                end
            end
            else if (!shadow_active)
            begin
                st = ST_REJECTED;   // nothing to continue, state untouched
            end
            else
            begin
                owed = shadow_total - shadow_received;
                if (n > CHUNK_BYTES || n > owed || (n < CHUNK_BYTES && n != owed) ||
                    shadow_chunks >= MAX_CHUNKS)
                begin
                    drop_shadow_transfer();
                    st = ST_REJECTED;
                end
                else
                begin
                    shadow_received += n;
                    shadow_chunks++;
                    if (shadow_received == shadow_total)
                    begin
                        shadow_active = 1'b0;
                        st = ST_COMPLETE;
                    end
                    else
                    begin
                        st = ST_ACCEPTED;
                    end
                end
            end
        end
        rep.status   = st;
        rep.received = shadow_received[10:0];
        rep.total    = shadow_total[15:0];
        rep.active   = shadow_active;
        return 1'b1;
    endfunction

    // a read position that is safe: a byte already written, or past the end of the store
    function automatic logic [10:0] pick_read_index();
        int unsigned p;
        if ($urandom_range(9) == 0)
            return 11'($urandom_range(2047, STORE_DEPTH));
        p = $urandom_range(STORE_DEPTH - 1);
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            if (shadow_written[p])
                return 11'(p);
            p = (p == 0) ? STORE_DEPTH - 1 : p - 1;
        end
        return 11'($urandom_range(2047, STORE_DEPTH));
    endfunction

    task automatic note_mismatch(string what, logic [15:0] exp_val, logic [15:0] act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("report %0d: %s expected %0d, got %0d", reports_checked, what,
                     exp_val, act_val);
    endtask

    // one input transaction: optional idle cycles, then hold push until full is low
    // at a rising edge; the shadow state advances at that edge
    task automatic send_item(mode_t m, logic [7:0] d, logic fe, logic [10:0] idx);
        result_t rep;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        mode       <= m;
        data_byte  <= d;
        frame_end  <= fe;
        read_index <= idx;
        do @(posedge clk); while (full);
        items_sent++;
        if (predict_report(m, d, fe, idx, rep))
            pending_reports.push_back(rep);
    endtask

    task automatic send_read(logic [10:0] idx);
        send_item(MODE_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    task automatic send_abandon();
        send_item(MODE_ABANDON, 8'($urandom), 1'($urandom), 11'($urandom));
    endtask

    // start frame: declared total low byte, high byte, then payload
    task automatic send_start_frame(int len, int unsigned declared);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = (i == 0) ? declared[7:0] : (i == 1) ? declared[15:8] : 8'($urandom);
            send_item(MODE_START, b, i == len - 1, 11'($urandom));
        end
    endtask

    task automatic send_cont_frame(int len);
        for (int i = 0; i < len; i++)
            send_item(MODE_CONT, 8'($urandom), i == len - 1, 11'($urandom));
    endtask

    task automatic random_noise();
        mode_t m;
        repeat ($urandom_range(12, 1))
        begin
            m = mode_t'($urandom_range(3));
            send_item(m, 8'($urandom), $urandom_range(7) == 0,
                      (m == MODE_READ) ? pick_read_index() : 11'($urandom));
        end
    endtask

    // abandon with nothing going on, and reads past the end of the store
    task automatic test_abandon_and_reads_past_store();
        send_item(MODE_ABANDON, 8'hFF, 1'b1, 11'h7FF);
        send_read(11'h7FF);
        send_read(11'(STORE_DEPTH));
        send_item(MODE_ABANDON, 8'h00, 1'b0, 11'h000);
    endtask

    // start frames shorter than a full chunk are single, whatever bytes came before
    task automatic test_single_start_frames();
        send_start_frame(1, $urandom);
        send_start_frame(2, $urandom);
        send_start_frame(5, $urandom);
        // continuation bytes judged as a start frame by their last byte
        repeat (2) send_item(MODE_CONT, 8'($urandom), 1'b0, 11'($urandom));
        send_item(MODE_START, 8'($urandom), 1'b1, 11'($urandom));
    endtask

    // continuation with no transfer going on is rejected
    task automatic test_inactive_continuation();
        send_cont_frame(3);
        // start bytes load a total, then a continuation byte closes it while idle
        send_item(MODE_START, 8'h34, 1'b0, 11'($urandom));
        send_item(MODE_START, 8'h12, 1'b0, 11'($urandom));
        send_item(MODE_CONT, 8'($urandom), 1'b1, 11'($urandom));
    endtask

    // accepted start frame, then a chunk longer than what is still owed
    task automatic test_owed_overrun();
        send_start_frame(START_LEN, CHUNK_BYTES + 10);
        send_cont_frame(11);
    endtask

    // shortest chunked record at full rate, with reads between and after the frames
    task automatic test_complete_transfer();
        no_idle = 1'b1;
        send_start_frame(START_LEN, CHUNK_BYTES + 1);
        send_read(pick_read_index());
        send_cont_frame(1);
        send_read(11'(CHUNK_BYTES));
        no_idle = 1'b0;
    endtask

    // receiver stops popping for a while so the block fills and pushes back
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        repeat (24) send_read(pick_read_index());
        send_start_frame(3, $urandom);
    endtask

    task automatic test_random_traffic();
        int unsigned items_before;
        int unsigned pick;
        items_before = items_sent;
        while (items_sent - items_before < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_start_frame($urandom_range(8, 1), $urandom);
            else if (pick < 55)
                repeat ($urandom_range(3, 1)) send_read(pick_read_index());
            else if (pick < 90)
                random_noise();
            else
                send_abandon();
        end
    endtask

    // receiver: random pop, full rate during the no-idle stretch, long hold on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pop <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // each popped transaction is checked against the oldest predicted report
    always @(posedge clk)
    begin : report_checker
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch("report with nothing pending, status", '0, 16'(status));
            end
            else
            begin
                want = pending_reports.pop_front();
                status_tally[want.status]++;
                if (status !== want.status)
                    note_mismatch("status", 16'(want.status), 16'(status));
                if (received_bytes !== want.received)
                    note_mismatch("received_bytes", 16'(want.received), 16'(received_bytes));
                if (declared_total !== want.total)
                    note_mismatch("declared_total", want.total, declared_total);
                if (transfer_active !== want.active)
                    note_mismatch("transfer_active", 16'(want.active), 16'(transfer_active));
                if (read_data !== want.rdata)
                    note_mismatch("read_data", 16'(want.rdata), 16'(read_data));
                reports_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin : progress_watch
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (push && full)
            input_stall_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d reports pending",
                     quiet_cycles, pending_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : sequencer
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_abandon_and_reads_past_store();
        test_single_start_frames();
        test_inactive_continuation();
        test_owed_overrun();
        test_complete_transfer();
        test_result_backpressure();
        test_random_traffic();

        push <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d reports: %0d completed, %0d accepted",
                 items_sent, reports_checked, status_tally[ST_COMPLETE],
                 status_tally[ST_ACCEPTED]);
        $display("%0d single frames, %0d rejects, %0d reads, input held off for %0d cycles",
                 status_tally[ST_SINGLE], status_tally[ST_REJECTED], status_tally[ST_READ],
                 input_stall_cycles);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_front.sv
hw/rtl/ccr_back.sv
hw/rtl/ccr_outq.sv
hw/rtl/chunked_config_reassembler.sv
sim/chunked_config_reassembler_test.sv
